// ===== hdl/ldr_pkg.sv =====
// Shared constants for the linkage r squared scoring pipeline.
// No dependencies; imported by ld_r_squared_score.
package ldr_pkg;

   localparam int COUNT_BITS_DEFAULT    = 24;
   localparam int FRACTION_BITS_DEFAULT = 16;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ZERO_CNT = 2'd1,
      ST_ZERO_DEN = 2'd2,
      ST_SAT      = 2'd3
   } status_type;

endpackage

// ===== hdl/ld_r_squared_score.sv =====
// Linkage r squared scorer: exact (N*j - a*b)^2 / (a*b*(N-a)*(N-b)) in Q1.F.
// Depends on ldr_pkg.
//
// channel | dir | handshake          | payload
// req     | in  | req_tvalid/tready  | tdata {count_joint,count_b,count_a}, tlast last_pair
// rsp     | out | rsp_tvalid/tready  | tdata r2_value, tuser status, tlast last_out
// csr     | in  | csr_valid/ready    | csr_data sample_count
//
// One pair enters per cycle unless the output beat is held. The pipeline has six stages of
// capture, multiply, partial-product sum and compare, one restoring division stage per
// quotient bit, and the output register. Reset (synchronous) empties the
// pipeline and sets sample_count to 1. When the output beat is held, the whole
// pipeline freezes in place; nothing is dropped or repeated.
module ld_r_squared_score #(
   parameter int COUNT_BITS    = ldr_pkg::COUNT_BITS_DEFAULT,
   parameter int FRACTION_BITS = ldr_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_tvalid,
   output logic                                       req_tready,
   // count_a, count_b, count_joint from bit 0 up, zero padded
   input  logic [((3*COUNT_BITS+7)/8)*8-1:0]          req_tdata,
   input  logic                                       req_tlast,
   output logic                                       rsp_tvalid,
   input  logic                                       rsp_tready,
   // r2_value, zero padded
   output logic [((FRACTION_BITS+1+7)/8)*8-1:0]       rsp_tdata,
   // status
   output logic [1:0]                                 rsp_tuser,
   output logic                                       rsp_tlast,
   input  logic                                       csr_valid,
   output logic                                       csr_ready,
   input  logic [COUNT_BITS-1:0]                      csr_data
);
   import ldr_pkg::*;

   localparam int C  = COUNT_BITS;
   localparam int F  = FRACTION_BITS;
   localparam int W  = 4*C + 1;
   localparam int OW = ((F+1+7)/8)*8;

   logic en;
   logic [C-1:0] n_ff;

   // sample count register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= C'(1);
      end else if (csr_valid) begin
         n_ff <= csr_data;
      end
   end

   // advance the whole pipe unless the output beat is held
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   // stage 1: capture beat
   logic         v1_ff, l1_ff;
   logic [C-1:0] a1_ff, b1_ff, j1_ff, n1_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
      end
      if (en) begin
         a1_ff <= req_tdata[C-1:0];
         b1_ff <= req_tdata[2*C-1:C];
         j1_ff <= req_tdata[3*C-1:2*C];
         n1_ff <= n_ff;
         l1_ff <= req_tlast;
      end
   end

   // stage 2: products N*j, a*b, complements, special-case flags
   logic           v2_ff, l2_ff, z2_ff, g2_ff;
   logic [2*C-1:0] nj2_ff, ab2_ff;
   logic [C-1:0]   na2_ff, nb2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
      if (en) begin
         nj2_ff <= (2*C)'(n1_ff) * (2*C)'(j1_ff);
         ab2_ff <= (2*C)'(a1_ff) * (2*C)'(b1_ff);
         na2_ff <= n1_ff - a1_ff;
         nb2_ff <= n1_ff - b1_ff;
         z2_ff  <= (a1_ff == '0) || (b1_ff == '0);
         g2_ff  <= (a1_ff >= n1_ff) || (b1_ff >= n1_ff);
         l2_ff  <= l1_ff;
      end
   end

   // stage 3: absolute difference, (N-a)*(N-b)
   logic           v3_ff, l3_ff, z3_ff, g3_ff;
   logic [2*C-1:0] d3_ff, ab3_ff, nn3_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
      if (en) begin
         d3_ff  <= (nj2_ff >= ab2_ff) ? (nj2_ff - ab2_ff) : (ab2_ff - nj2_ff);
         nn3_ff <= (2*C)'(na2_ff) * (2*C)'(nb2_ff);
         ab3_ff <= ab2_ff;
         z3_ff  <= z2_ff;
         g3_ff  <= g2_ff;
         l3_ff  <= l2_ff;
      end
   end

   // stage 4: half-width partial products of diff^2 and ab*nn
   logic           v4_ff, l4_ff, z4_ff, g4_ff;
   logic [2*C-1:0] dll_ff, dlh_ff, dhh_ff, pll_ff, plh_ff, phl_ff, phh_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
      if (en) begin
         dll_ff <= (2*C)'(d3_ff[C-1:0])    * (2*C)'(d3_ff[C-1:0]);
         dlh_ff <= (2*C)'(d3_ff[C-1:0])    * (2*C)'(d3_ff[2*C-1:C]);
         dhh_ff <= (2*C)'(d3_ff[2*C-1:C])  * (2*C)'(d3_ff[2*C-1:C]);
         pll_ff <= (2*C)'(ab3_ff[C-1:0])   * (2*C)'(nn3_ff[C-1:0]);
         plh_ff <= (2*C)'(ab3_ff[C-1:0])   * (2*C)'(nn3_ff[2*C-1:C]);
         phl_ff <= (2*C)'(ab3_ff[2*C-1:C]) * (2*C)'(nn3_ff[C-1:0]);
         phh_ff <= (2*C)'(ab3_ff[2*C-1:C]) * (2*C)'(nn3_ff[2*C-1:C]);
         z4_ff  <= z3_ff;
         g4_ff  <= g3_ff;
         l4_ff  <= l3_ff;
      end
   end

   // stage 5: sum partial products into numerator and denominator
   logic           v5_ff, l5_ff, z5_ff, g5_ff;
   logic [4*C-1:0] num5_ff, den5_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= v4_ff;
      end
      if (en) begin
         num5_ff <= ((4*C)'(dhh_ff) << (2*C)) + ((4*C)'(dlh_ff) << (C+1))
                    + (4*C)'(dll_ff);
         den5_ff <= ((4*C)'(phh_ff) << (2*C)) + ((4*C)'(plh_ff) << C)
                    + ((4*C)'(phl_ff) << C) + (4*C)'(pll_ff);
         z5_ff   <= z4_ff;
         g5_ff   <= g4_ff;
         l5_ff   <= l4_ff;
      end
   end

   // stage 6: compare, settle status; division stages follow
   logic         dv_ff  [0:F];
   logic         dl_ff  [0:F];
   logic         done_ff[0:F];
   status_type   dst_ff [0:F];
   logic [W-1:0] dr_ff  [0:F];
   logic [W-1:0] dd_ff  [0:F];
   logic [F-1:0] dq_ff  [0:F];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= v5_ff;
      end
      if (en) begin
         dr_ff[0] <= W'(num5_ff);
         dd_ff[0] <= W'(den5_ff);
         dq_ff[0] <= '0;
         dl_ff[0] <= l5_ff;
         if (z5_ff) begin
            dst_ff[0]  <= ST_ZERO_CNT;
            done_ff[0] <= 1'b0;
         end else if (g5_ff) begin
            dst_ff[0]  <= ST_ZERO_DEN;
            done_ff[0] <= 1'b0;
         end else if (num5_ff > den5_ff) begin
            dst_ff[0]  <= ST_SAT;
            done_ff[0] <= 1'b1;
         end else begin
            dst_ff[0]  <= ST_OK;
            done_ff[0] <= (num5_ff == den5_ff);
         end
      end
   end

   // one restoring division step per stage
   for (genvar k = 1; k <= F; k++) begin : g_div
      logic [W-1:0] shl;
      logic [W:0]   dif;
      assign shl = {dr_ff[k-1][W-2:0], 1'b0};
      assign dif = {1'b0, shl} - {1'b0, dd_ff[k-1]};
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k] <= 1'b0;
         end else if (en) begin
            dv_ff[k] <= dv_ff[k-1];
         end
         if (en) begin
            dr_ff[k]   <= dif[W] ? shl : dif[W-1:0];
            dq_ff[k]   <= {dq_ff[k-1][F-2:0], !dif[W]};
            dd_ff[k]   <= dd_ff[k-1];
            dst_ff[k]  <= dst_ff[k-1];
            done_ff[k] <= done_ff[k-1];
            dl_ff[k]   <= dl_ff[k-1];
         end
      end
   end

   // output register
   logic         ov_ff, ol_ff;
   logic [F:0]   oval_ff;
   status_type   ost_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= dv_ff[F];
      end
      if (en) begin
         ost_ff <= dst_ff[F];
         ol_ff  <= dl_ff[F];
         if (done_ff[F]) begin
            oval_ff <= (F+1)'(1) << F;
         end else if (dst_ff[F] == ST_OK) begin
            oval_ff <= {1'b0, dq_ff[F]};
         end else begin
            oval_ff <= '0;
         end
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = OW'(oval_ff);
   assign rsp_tuser  = ost_ff;
   assign rsp_tlast  = ol_ff;

endmodule
